### sv/jsl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// jsl_pkg
// Types, constants and the keyword table shared by the Jack source lexer.
// ============================================================================
package jsl_pkg;

    // Field widths of the token record
    localparam int POSITION_WIDTH = 24;
    localparam int LENGTH_WIDTH   = 16;
    localparam int CHAR_WIDTH     = 8;
    localparam int KIND_WIDTH     = 3;
    localparam int CODE_WIDTH     = 5;
    localparam int VALUE_WIDTH    = 15;

    // Keyword buffer and table
    localparam int KW_SLOTS     = 11;
    localparam int KW_COUNT     = 21;
    localparam int KW_IDX_WIDTH = $clog2(KW_SLOTS);

    localparam logic [VALUE_WIDTH-1:0]  INT_MAX_VALUE = '1;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX       = '1;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Packed result beat: code, symbol, value, overflow, start, length
    localparam int REC_DATA_BITS = CODE_WIDTH + CHAR_WIDTH + VALUE_WIDTH + 1
                                   + POSITION_WIDTH + LENGTH_WIDTH;
    localparam int M_TDATA_WIDTH = ((REC_DATA_BITS + 7) / 8) * 8;

    // Character codes
    localparam logic [CHAR_WIDTH-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_WIDTH-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_WIDTH-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        LM_IDLE   = 3'd0,
        LM_WORD   = 3'd1,
        LM_NUMBER = 3'd2,
        LM_STRING = 3'd3,
        LM_SLASH  = 3'd4,
        LM_LINE   = 3'd5,
        LM_BLOCK  = 3'd6,
        LM_BSTAR  = 3'd7
    } lex_mode_t;

    typedef enum logic [KIND_WIDTH-1:0] {
        TK_KEYWORD = 3'd0,
        TK_SYMBOL  = 3'd1,
        TK_INTEGER = 3'd2,
        TK_STRING  = 3'd3,
        TK_IDENT   = 3'd4,
        TK_UNKNOWN = 3'd5,
        TK_UNTERM  = 3'd6
    } tok_kind_t;

    typedef logic [KW_SLOTS-1:0][CHAR_WIDTH-1:0] kw_text_t;

    typedef struct packed {
        tok_kind_t                  kind;
        logic [CODE_WIDTH-1:0]      code;
        logic [CHAR_WIDTH-1:0]      sym;
        logic [VALUE_WIDTH-1:0]     value;
        logic                       ovf;
        logic [POSITION_WIDTH-1:0]  start;
        logic [LENGTH_WIDTH-1:0]    len;
        logic                       last;
    } tok_rec_t;

    typedef struct packed {
        logic                  hit;
        logic [CODE_WIDTH-1:0] code;
    } kw_hit_t;

    // Literals are right-justified: first letter sits in byte len-1
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        kw_text_t'("class"),   kw_text_t'("constructor"), kw_text_t'("function"),
        kw_text_t'("method"),  kw_text_t'("field"),       kw_text_t'("static"),
        kw_text_t'("var"),     kw_text_t'("int"),         kw_text_t'("char"),
        kw_text_t'("boolean"), kw_text_t'("void"),        kw_text_t'("true"),
        kw_text_t'("false"),   kw_text_t'("null"),        kw_text_t'("this"),
        kw_text_t'("let"),     kw_text_t'("do"),          kw_text_t'("if"),
        kw_text_t'("else"),    kw_text_t'("while"),       kw_text_t'("return")
    };

    localparam logic [KW_IDX_WIDTH-1:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd11, 4'd8, 4'd6, 4'd5, 4'd6, 4'd3, 4'd3, 4'd4, 4'd7, 4'd4,
        4'd4, 4'd5,  4'd4, 4'd4, 4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd6
    };

    // Parallel compare of the word buffer against all keywords
    function automatic kw_hit_t kw_lookup(input kw_text_t wbuf,
                                          input logic [LENGTH_WIDTH-1:0] wlen);
        kw_hit_t           res;
        logic              same;
        logic [KW_IDX_WIDTH-1:0] idx;
        res = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            same = (wlen == LENGTH_WIDTH'(KW_LEN[i]));
            for (int k = 0; k < KW_SLOTS; k++) begin
                if (k < int'(KW_LEN[i])) begin
                    idx = KW_IDX_WIDTH'(int'(KW_LEN[i]) - 1 - k);
                    if (wbuf[k] != KW_TEXT[i][idx]) begin
                        same = 1'b0;
                    end
                end
            end
            if (same && !res.hit) begin
                res.hit  = 1'b1;
                res.code = CODE_WIDTH'(i);
            end
        end
        return res;
    endfunction

endpackage

### sv/jack_source_lexer.sv
`timescale 1ns / 1ps
// ============================================================================
// jack_source_lexer
// Byte-serial Jack tokenizer: drops comments, emits one record per token.
// ============================================================================
// Path: a beat is held in the input register, decoded once the result queue
//   has room, and its records are written to the queue that drives m_.
// Throughput: one byte per cycle while the queue has room for two records;
//   a byte that yields two records writes both at once; they leave in order.
// Reset: aresetn (synchronous, active low) empties the input register and the
//   4-entry result queue, sets the mode to idle and clears position counters.
module jack_source_lexer
    import jsl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // s_tdata: [7:0] char_in
    input  logic [7:0]               s_tdata,
    input  logic                     s_tlast,   // end_of_text
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // m_tdata: keyword_code, symbol_char, int_value, int_overflow,
    //          token_start, token_length (lowest bit up), zero pad
    output logic [M_TDATA_WIDTH-1:0] m_tdata,
    output logic [KIND_WIDTH-1:0]    m_tuser,   // token_kind
    output logic                     m_tlast,   // run_end
    output logic                     m_tvalid,
    input  logic                     m_tready
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                       in_valid_reg;
    logic [CHAR_WIDTH-1:0]      in_char_reg;
    logic                       in_eot_reg;

    lex_mode_t                  mode_reg, mode1, mode_next;
    kw_text_t                   kw_buf_reg, buf1;
    logic [LENGTH_WIDTH-1:0]    cnt_reg, cnt1;
    logic [POSITION_WIDTH-1:0]  org_reg, org1;
    logic [POSITION_WIDTH-1:0]  pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0]     num_reg, num1;
    logic                       sat_reg, sat1;

    tok_rec_t                   fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]         rd_ptr_reg, wr_ptr_reg;
    logic [FIFO_AW:0]           fill_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic fire, pop;
    logic [1:0] push_n;

    assign fire     = in_valid_reg && (fill_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || fire;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    logic [CHAR_WIDTH-1:0] c;
    logic is_alpha, is_digit, is_space, is_quote, is_slash, is_star, is_sym;

    assign c        = in_char_reg;
    assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                      || (c == CH_UNDER);
    assign is_digit = (c >= 8'h30 && c <= 8'h39);
    assign is_space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    assign is_quote = (c == CH_QUOTE);
    assign is_slash = (c == CH_SLASH);
    assign is_star  = (c == CH_STAR);

    always_comb begin
        case (c)
            8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2E, 8'h2C, 8'h3B,
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h26, 8'h7C, 8'h3C, 8'h3E, 8'h3D,
            8'h7E:   is_sym = 1'b1;
            default: is_sym = 1'b0;
        endcase
    end

    function automatic logic [LENGTH_WIDTH-1:0] count_up(input logic [LENGTH_WIDTH-1:0] v);
        return (v == LEN_MAX) ? v : v + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Next state: byte step, then the end-of-text reset of mode/position
    // ------------------------------------------------------------------
    logic                     start_tok;
    logic [VALUE_WIDTH+3:0]   num_prod;

    assign num_prod = {4'b0, num_reg} * (VALUE_WIDTH+4)'(10)
                      + (VALUE_WIDTH+4)'(c - CH_ZERO);

    always_comb begin
        mode1     = mode_reg;
        buf1      = kw_buf_reg;
        cnt1      = cnt_reg;
        org1      = org_reg;
        num1      = num_reg;
        sat1      = sat_reg;
        start_tok = 1'b0;
        case (mode_reg)
            LM_WORD: begin
                if (is_alpha || is_digit) begin
                    if (cnt_reg < LENGTH_WIDTH'(KW_SLOTS)) begin
                        buf1[cnt_reg[KW_IDX_WIDTH-1:0]] = c;
                    end
                    cnt1 = count_up(cnt_reg);
                end else begin
                    start_tok = 1'b1;
                end
            end
            LM_NUMBER: begin
                if (is_digit) begin
                    if (!sat_reg) begin
                        if (num_prod > (VALUE_WIDTH+4)'(INT_MAX_VALUE)) begin
                            num1 = INT_MAX_VALUE;
                            sat1 = 1'b1;
                        end else begin
                            num1 = num_prod[VALUE_WIDTH-1:0];
                        end
                    end
                    cnt1 = count_up(cnt_reg);
                end else begin
                    start_tok = 1'b1;
                end
            end
            LM_STRING: begin
                if (is_quote) begin
                    mode1 = LM_IDLE;
                end else begin
                    cnt1 = count_up(cnt_reg);
                end
            end
            LM_SLASH: begin
                if (is_slash) begin
                    mode1 = LM_LINE;
                end else if (is_star) begin
                    mode1 = LM_BLOCK;
                end else begin
                    start_tok = 1'b1;
                end
            end
            LM_LINE: begin
                if (c == CH_NL) mode1 = LM_IDLE;
            end
            LM_BLOCK: begin
                if (is_star) mode1 = LM_BSTAR;
            end
            LM_BSTAR: begin
                if (is_slash) begin
                    mode1 = LM_IDLE;
                end else if (!is_star) begin
                    mode1 = LM_BLOCK;
                end
            end
            default: begin
                start_tok = 1'b1;
            end
        endcase

        // Start of a new token at the current byte
        if (start_tok) begin
            mode1 = LM_IDLE;
            if (!is_space) begin
                org1 = pos_reg;
                if (is_alpha) begin
                    mode1   = LM_WORD;
                    buf1[0] = c;
                    cnt1    = LENGTH_WIDTH'(1);
                end else if (is_digit) begin
                    mode1 = LM_NUMBER;
                    num1  = VALUE_WIDTH'(c - CH_ZERO);
                    sat1  = 1'b0;
                    cnt1  = LENGTH_WIDTH'(1);
                end else if (is_quote) begin
                    mode1 = LM_STRING;
                    cnt1  = '0;
                end else if (is_slash) begin
                    mode1 = LM_SLASH;
                end
            end
        end

        mode_next = in_eot_reg ? LM_IDLE : mode1;
        pos_next  = in_eot_reg ? '0 : pos_reg + 1'b1;
    end

    // ------------------------------------------------------------------
    // Records: closed token, single-byte token, end-of-text flush
    // ------------------------------------------------------------------
    kw_hit_t  kwa, kwb;
    tok_rec_t rec_a, rec_b, rec_c, rec0, rec1;
    logic     va, vb, vc;
    logic [1:0] rec_n;

    assign kwa = kw_lookup(kw_buf_reg, cnt_reg);
    assign kwb = kw_lookup(buf1, cnt1);

    always_comb begin
        rec_a = '0;
        rec_b = '0;
        rec_c = '0;
        va    = 1'b0;
        vb    = 1'b0;
        vc    = 1'b0;

        // Token closed by this byte, from the stored state
        rec_a.start = org_reg;
        rec_a.len   = cnt_reg;
        case (mode_reg)
            LM_WORD: begin
                va         = start_tok;
                rec_a.kind = kwa.hit ? TK_KEYWORD : TK_IDENT;
                rec_a.code = kwa.hit ? kwa.code : '0;
            end
            LM_NUMBER: begin
                va          = start_tok;
                rec_a.kind  = TK_INTEGER;
                rec_a.value = num_reg;
                rec_a.ovf   = sat_reg;
            end
            LM_STRING: begin
                va         = is_quote;
                rec_a.kind = TK_STRING;
            end
            LM_SLASH: begin
                va         = start_tok;
                rec_a.kind = TK_SYMBOL;
                rec_a.sym  = CH_SLASH;
                rec_a.len  = LENGTH_WIDTH'(1);
            end
            default: begin
                va = 1'b0;
            end
        endcase

        // Symbol or unknown byte that stands alone
        vb          = start_tok && !is_space && !is_alpha && !is_digit
                      && !is_quote && !is_slash;
        rec_b.kind  = is_sym ? TK_SYMBOL : TK_UNKNOWN;
        rec_b.sym   = c;
        rec_b.start = pos_reg;
        rec_b.len   = LENGTH_WIDTH'(1);

        // Flush of a pending token at end of text
        rec_c.start = org1;
        rec_c.len   = cnt1;
        case (mode1)
            LM_WORD: begin
                vc         = in_eot_reg;
                rec_c.kind = kwb.hit ? TK_KEYWORD : TK_IDENT;
                rec_c.code = kwb.hit ? kwb.code : '0;
            end
            LM_NUMBER: begin
                vc          = in_eot_reg;
                rec_c.kind  = TK_INTEGER;
                rec_c.value = num1;
                rec_c.ovf   = sat1;
            end
            LM_STRING: begin
                vc         = in_eot_reg;
                rec_c.kind = TK_UNTERM;
            end
            LM_SLASH: begin
                vc         = in_eot_reg;
                rec_c.kind = TK_SYMBOL;
                rec_c.sym  = CH_SLASH;
                rec_c.len  = LENGTH_WIDTH'(1);
            end
            default: begin
                vc = 1'b0;
            end
        endcase

        // At most two of the three are ever set; keep their order
        rec0  = va ? rec_a : (vb ? rec_b : rec_c);
        rec1  = (va && vb) ? rec_b : rec_c;
        rec_n = 2'(va) + 2'(vb) + 2'(vc);
        rec0.last = (rec_n == 2'd1);
        rec1.last = 1'b1;
    end

    assign push_n = fire ? rec_n : 2'd0;

    // ------------------------------------------------------------------
    // Lexer state registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= LM_IDLE;
            cnt_reg  <= '0;
            org_reg  <= '0;
            pos_reg  <= '0;
            num_reg  <= '0;
            sat_reg  <= 1'b0;
        end else if (fire) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt1;
            org_reg  <= org1;
            pos_reg  <= pos_next;
            num_reg  <= num1;
            sat_reg  <= sat1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            kw_buf_reg <= buf1;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= rec0;
        end
        if (push_n == 2'd2) begin
            fifo_mem[wr_ptr_reg + 1'b1] <= rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            fill_reg   <= fill_reg + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
        end
    end

    // Result beat
    tok_rec_t head;

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (fill_reg != '0);
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = M_TDATA_WIDTH'({head.len, head.start, head.ovf, head.value,
                                      head.sym, head.code});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_eot_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_eot_reg) |=> (mode_reg == LM_IDLE && pos_reg == '0))
        else $error("end of text did not return lexer to idle");

    a_kw_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && head.kind == TK_KEYWORD) |->
            (head.len >= LENGTH_WIDTH'(2) && head.len <= LENGTH_WIDTH'(KW_SLOTS)))
        else $error("keyword record with impossible length");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n == 2'd2) |-> (fill_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2)))
        else $error("double push without room");

    a_int_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && head.ovf) |-> (head.kind == TK_INTEGER && head.value == INT_MAX_VALUE))
        else $error("overflow flag on non-saturated record");

endmodule
